>>> hw/rtl/isas_pkg.sv
// Shared types and constants for the incubator setpoint and alarm supervisor.
// No dependencies; every other file imports this package.
package isas_pkg;

  localparam int TEMP_W   = 12;
  localparam int HOST_W   = 15;
  localparam int SECS_W   = 32;
  localparam int MS_W     = 11;
  localparam int TICKMS_W = 10;
  localparam int BAND_W   = 9;
  localparam int CNT16_W  = 16;
  localparam int ERR_W    = 12;
  localparam int BEST_W   = 14;
  localparam int ALU_W    = 33;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_ALARM = 2'd3;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_KEY       = 2'd1;
  localparam logic [1:0] OP_HOST_SET  = 2'd2;
  localparam logic [1:0] OP_HOST_STOP = 2'd3;

  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_ACCEPT = 2'd1;
  localparam logic [1:0] REPLY_RANGE  = 2'd2;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  localparam logic [2:0] CFG_IDX_BAND    = 3'd0;
  localparam logic [2:0] CFG_IDX_MIN     = 3'd1;
  localparam logic [2:0] CFG_IDX_MAX     = 3'd2;
  localparam logic [2:0] CFG_IDX_DEFAULT = 3'd3;
  localparam logic [2:0] CFG_IDX_STARTUP = 3'd4;
  localparam logic [2:0] CFG_IDX_STUCK   = 3'd5;
  localparam logic [2:0] CFG_IDX_TICKMS  = 3'd6;

  localparam logic [MS_W-1:0] MS_PER_SEC = 11'd1000;

  localparam logic [BAND_W-1:0]   BAND_RST    = 9'd20;
  localparam logic [TEMP_W-1:0]   MIN_RST     = 12'd200;
  localparam logic [TEMP_W-1:0]   MAX_RST     = 12'd600;
  localparam logic [TEMP_W-1:0]   DEFAULT_RST = 12'd370;
  localparam logic [CNT16_W-1:0]  STARTUP_RST = 16'd3000;
  localparam logic [CNT16_W-1:0]  STUCK_RST   = 16'd300;
  localparam logic [TICKMS_W-1:0] TICKMS_RST  = 10'd200;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef struct packed {
    logic [BAND_W-1:0]   alarm_band;
    temp_t               min_target;
    temp_t               max_target;
    temp_t               default_target;
    logic [CNT16_W-1:0]  startup_ticks;
    logic [CNT16_W-1:0]  stuck_ticks;
    logic [TICKMS_W-1:0] tick_ms;
    logic                load_default;
  } cfg_regs_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
  } alu_rsp_t;

endpackage

>>> hw/rtl/isas_if.sv
// Valid/ready channel interfaces for the supervisor's input and result words.
// Depends on isas_pkg for field widths.
interface isas_in_if import isas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [TEMP_W-1:0] measured_temp;
  logic [3:0]               key_code;
  logic signed [HOST_W-1:0] host_target;

  modport source (output valid, opcode, measured_temp, key_code, host_target, input ready);
  modport sink (input valid, opcode, measured_temp, key_code, host_target, output ready);
endinterface

interface isas_out_if import isas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic                     buzzer_on;
  logic signed [TEMP_W-1:0] target_temp;
  logic [SECS_W-1:0]        run_seconds;
  logic                     control_active;
  logic                     controller_reset;
  logic                     drive_stop;
  logic [1:0]               host_reply;

  modport source (output valid, mode, buzzer_on, target_temp, run_seconds, control_active,
                  controller_reset, drive_stop, host_reply, input ready);
  modport sink (input valid, mode, buzzer_on, target_temp, run_seconds, control_active,
                controller_reset, drive_stop, host_reply, output ready);
endinterface

>>> hw/rtl/isas_alu.sv
// Shared 33-bit add/subtract unit used by the supervisor sequencer.
// Depends on isas_pkg for the request and response structs.
module isas_alu import isas_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] sum;

  assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.sum = sum;
  assign rsp.neg = sum[ALU_W-1];

endmodule

>>> hw/rtl/isas_cfg.sv
// APB-style configuration register file for the supervisor.
// Depends on isas_pkg for register indexes, reset values and cfg_regs_t.
module isas_cfg import isas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  logic [BAND_W-1:0]   band_r;
  logic [TEMP_W-1:0]   min_r;
  logic [TEMP_W-1:0]   max_r;
  logic [TEMP_W-1:0]   default_r;
  logic [CNT16_W-1:0]  startup_r;
  logic [CNT16_W-1:0]  stuck_r;
  logic [TICKMS_W-1:0] tickms_r;
  logic                load_r;
  logic                wr;
  logic [2:0]          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r    <= BAND_RST;
      min_r     <= MIN_RST;
      max_r     <= MAX_RST;
      default_r <= DEFAULT_RST;
      startup_r <= STARTUP_RST;
      stuck_r   <= STUCK_RST;
      tickms_r  <= TICKMS_RST;
      load_r    <= 1'b0;
    end else begin
      load_r <= wr && (idx == CFG_IDX_DEFAULT);
      if (wr) begin
        unique case (idx)
          CFG_IDX_BAND:    band_r    <= pwdata[BAND_W-1:0];
          CFG_IDX_MIN:     min_r     <= pwdata[TEMP_W-1:0];
          CFG_IDX_MAX:     max_r     <= pwdata[TEMP_W-1:0];
          CFG_IDX_DEFAULT: default_r <= pwdata[TEMP_W-1:0];
          CFG_IDX_STARTUP: startup_r <= pwdata[CNT16_W-1:0];
          CFG_IDX_STUCK:   stuck_r   <= pwdata[CNT16_W-1:0];
          CFG_IDX_TICKMS:  tickms_r  <= pwdata[TICKMS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      CFG_IDX_BAND:    prdata = APB_DW'(band_r);
      CFG_IDX_MIN:     prdata = APB_DW'(min_r);
      CFG_IDX_MAX:     prdata = APB_DW'(max_r);
      CFG_IDX_DEFAULT: prdata = APB_DW'(default_r);
      CFG_IDX_STARTUP: prdata = APB_DW'(startup_r);
      CFG_IDX_STUCK:   prdata = APB_DW'(stuck_r);
      CFG_IDX_TICKMS:  prdata = APB_DW'(tickms_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.alarm_band     = band_r;
  assign cfg.min_target     = min_r;
  assign cfg.max_target     = max_r;
  assign cfg.default_target = default_r;
  assign cfg.startup_ticks  = startup_r;
  assign cfg.stuck_ticks    = stuck_r;
  assign cfg.tick_ms        = tickms_r;
  assign cfg.load_default   = load_r;

endmodule

>>> hw/rtl/incubator_setpoint_and_alarm_supervisor.sv
// Top level of the incubator setpoint and alarm supervisor.
// Depends on isas_pkg, isas_if (channels), isas_cfg and isas_alu.
//
// Usage:
//   in_ch  : one word per event (tick, key press, host set target, host stop).
//   out_ch : exactly one result word per input word: mode, buzzer, target,
//            run seconds and the per-event pulses and host reply.
//   cfg_*  : APB-style register port, registers at byte address 4*i; write
//            only while the block is idle.
// Timing: a small sequencer drives one shared 33-bit adder, one operation
// per cycle. A tick steps through abs error, blanking, band, best error,
// stuck count and run time with up to two seconds carries; a keypad confirm
// does one add per digit, a multiply-by-ten between digits and one more for
// entries of under three digits, then the limit compares.
// in_ch.ready is high only while the sequencer is idle; it returns high the
// cycle after the result is loaded into the output register, so the next
// word can be taken while out_ch still holds an unread result. If out_ch
// stalls with a result pending, the next result waits in the sequencer.
// Reset: mode idle, target 37.0 degrees, counters and run time cleared,
// registers at their documented defaults, no result pending.
module incubator_setpoint_and_alarm_supervisor import isas_pkg::*; #(
  parameter int MAX_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  isas_in_if.sink           in_ch,
  isas_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_T_DIFF  = 5'd1;
  localparam logic [4:0] ST_T_ABS   = 5'd2;
  localparam logic [4:0] ST_T_BLANK = 5'd3;
  localparam logic [4:0] ST_T_BINC  = 5'd4;
  localparam logic [4:0] ST_T_BAND  = 5'd5;
  localparam logic [4:0] ST_T_BEST  = 5'd6;
  localparam logic [4:0] ST_T_NGINC = 5'd7;
  localparam logic [4:0] ST_T_STUCK = 5'd8;
  localparam logic [4:0] ST_T_MS    = 5'd9;
  localparam logic [4:0] ST_T_SEC   = 5'd10;
  localparam logic [4:0] ST_T_SINC  = 5'd11;
  localparam logic [4:0] ST_KEY     = 5'd12;
  localparam logic [4:0] ST_K_MUL   = 5'd13;
  localparam logic [4:0] ST_K_ADD   = 5'd14;
  localparam logic [4:0] ST_K_X10   = 5'd15;
  localparam logic [4:0] ST_K_FIN   = 5'd16;
  localparam logic [4:0] ST_RNG_MIN = 5'd17;
  localparam logic [4:0] ST_RNG_MAX = 5'd18;
  localparam logic [4:0] ST_STOP    = 5'd19;
  localparam logic [4:0] ST_DONE    = 5'd20;

  cfg_regs_t cfg;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  logic [4:0]               state_r,     state_nxt;
  logic signed [TEMP_W-1:0] meas_r,      meas_nxt;
  logic [3:0]               key_r,       key_nxt;
  logic signed [HOST_W-1:0] cand_r,      cand_nxt;
  logic                     host_r,      host_nxt;
  logic signed [TEMP_W:0]   diff_r,      diff_nxt;
  logic [ERR_W-1:0]         err_r,       err_nxt;
  logic [IDX_W-1:0]         idx_r,       idx_nxt;
  logic [1:0]               mode_r,      mode_nxt;
  logic signed [TEMP_W-1:0] target_r,    target_nxt;
  logic [CNT_W-1:0]         count_r,     count_nxt;
  logic [CNT16_W-1:0]       blank_r,     blank_nxt;
  logic [BEST_W-1:0]        best_r,      best_nxt;
  logic [CNT16_W-1:0]       nogain_r,    nogain_nxt;
  logic                     buzzer_r,    buzzer_nxt;
  logic [MS_W-1:0]          millis_r,    millis_nxt;
  logic [SECS_W-1:0]        secs_r,      secs_nxt;
  logic                     active_r,    active_nxt;
  logic                     pid_r,       pid_nxt;
  logic                     stop_r,      stop_nxt;
  logic [1:0]               reply_r,     reply_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               store_r [MAX_DIGITS];
  logic                     store_we;
  logic                     in_fire;
  logic                     out_load;
  logic                     last_digit;

  logic [1:0]               out_mode_r;
  logic                     out_buzzer_r;
  logic signed [TEMP_W-1:0] out_target_r;
  logic [SECS_W-1:0]        out_secs_r;
  logic                     out_active_r;
  logic                     out_pid_r;
  logic                     out_stop_r;
  logic [1:0]               out_reply_r;

  isas_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  isas_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign last_digit  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt  = state_r;
    meas_nxt   = meas_r;
    key_nxt    = key_r;
    cand_nxt   = cand_r;
    host_nxt   = host_r;
    diff_nxt   = diff_r;
    err_nxt    = err_r;
    idx_nxt    = idx_r;
    mode_nxt   = mode_r;
    target_nxt = target_r;
    count_nxt  = count_r;
    blank_nxt  = blank_r;
    best_nxt   = best_r;
    nogain_nxt = nogain_r;
    buzzer_nxt = buzzer_r;
    millis_nxt = millis_r;
    secs_nxt   = secs_r;
    active_nxt = active_r;
    pid_nxt    = pid_r;
    stop_nxt   = stop_r;
    reply_nxt  = reply_r;
    store_we   = 1'b0;
    out_load   = 1'b0;
    alu_req    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          meas_nxt   = in_ch.measured_temp;
          key_nxt    = in_ch.key_code;
          cand_nxt   = in_ch.host_target;
          host_nxt   = 1'b0;
          active_nxt = 1'b0;
          pid_nxt    = 1'b0;
          stop_nxt   = 1'b0;
          reply_nxt  = REPLY_NONE;
          unique case (in_ch.opcode)
            OP_TICK:      state_nxt = ST_T_DIFF;
            OP_KEY:       state_nxt = ST_KEY;
            OP_HOST_SET: begin
              host_nxt  = 1'b1;
              state_nxt = ST_RNG_MIN;
            end
            OP_HOST_STOP: state_nxt = ST_STOP;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_T_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'($signed(meas_r));
        alu_req.b   = ALU_W'($signed(target_r));
        diff_nxt    = alu_rsp.sum[TEMP_W:0];
        state_nxt   = ST_T_ABS;
      end

      ST_T_ABS: begin
        alu_req.sub = diff_r[TEMP_W];
        alu_req.a   = '0;
        alu_req.b   = ALU_W'($signed(diff_r));
        err_nxt     = alu_rsp.sum[ERR_W-1:0];
        if (mode_r != MODE_RUN && mode_r != MODE_ALARM) begin
          buzzer_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_T_BLANK;
        end
      end

      ST_T_BLANK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(blank_r);
        alu_req.b   = ALU_W'(cfg.startup_ticks);
        if (alu_rsp.neg) begin
          buzzer_nxt = 1'b0;
          state_nxt  = ST_T_BINC;
        end else begin
          state_nxt = ST_T_BAND;
        end
      end

      ST_T_BINC: begin
        alu_req.a = ALU_W'(blank_r);
        alu_req.b = ALU_W'(1);
        blank_nxt = alu_rsp.sum[CNT16_W-1:0];
        state_nxt = ST_T_MS;
      end

      ST_T_BAND: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(cfg.alarm_band);
        alu_req.b   = ALU_W'(err_r);
        if (!alu_rsp.neg) begin
          nogain_nxt = '0;
          best_nxt   = '0;
          buzzer_nxt = 1'b0;
          if (mode_r == MODE_ALARM) begin
            mode_nxt = MODE_RUN;
          end
          state_nxt = ST_T_MS;
        end else begin
          state_nxt = ST_T_BEST;
        end
      end

      ST_T_BEST: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(err_r);
        alu_req.b   = ALU_W'(best_r);
        if (best_r == '0 || alu_rsp.neg) begin
          best_nxt   = BEST_W'(err_r);
          nogain_nxt = '0;
          state_nxt  = ST_T_STUCK;
        end else if (nogain_r != '1) begin
          state_nxt = ST_T_NGINC;
        end else begin
          state_nxt = ST_T_STUCK;
        end
      end

      ST_T_NGINC: begin
        alu_req.a  = ALU_W'(nogain_r);
        alu_req.b  = ALU_W'(1);
        nogain_nxt = alu_rsp.sum[CNT16_W-1:0];
        state_nxt  = ST_T_STUCK;
      end

      ST_T_STUCK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(nogain_r);
        alu_req.b   = ALU_W'(cfg.stuck_ticks);
        if (!alu_rsp.neg) begin
          mode_nxt   = MODE_ALARM;
          buzzer_nxt = 1'b1;
        end
        state_nxt = ST_T_MS;
      end

      ST_T_MS: begin
        active_nxt = 1'b1;
        alu_req.a  = ALU_W'(millis_r);
        alu_req.b  = ALU_W'(cfg.tick_ms);
        millis_nxt = alu_rsp.sum[MS_W-1:0];
        state_nxt  = ST_T_SEC;
      end

      ST_T_SEC: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(millis_r);
        alu_req.b   = ALU_W'(MS_PER_SEC);
        if (!alu_rsp.neg) begin
          millis_nxt = alu_rsp.sum[MS_W-1:0];
          state_nxt  = ST_T_SINC;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_T_SINC: begin
        alu_req.a = ALU_W'(secs_r);
        alu_req.b = ALU_W'(1);
        secs_nxt  = alu_rsp.sum[SECS_W-1:0];
        state_nxt = ST_T_SEC;
      end

      ST_KEY: begin
        state_nxt = ST_DONE;
        unique case (key_r)
          KEY_STAR: begin
            if (mode_r == MODE_SET) begin
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end else begin
              mode_nxt  = MODE_SET;
              count_nxt = '0;
            end
          end
          KEY_HASH: begin
            if (mode_r == MODE_SET) begin
              cand_nxt = '0;
              idx_nxt  = '0;
              state_nxt = (count_r != '0) ? ST_K_ADD : ST_K_FIN;
            end else if (mode_r == MODE_RUN) begin
              mode_nxt   = MODE_IDLE;
              stop_nxt   = 1'b1;
              secs_nxt   = '0;
              millis_nxt = '0;
            end else begin
              mode_nxt   = MODE_RUN;
              blank_nxt  = '0;
              best_nxt   = '0;
              nogain_nxt = '0;
              buzzer_nxt = 1'b0;
              secs_nxt   = '0;
              millis_nxt = '0;
            end
          end
          default: begin
            if (mode_r == MODE_SET && key_r <= KEY_DIGIT_MAX &&
                count_r < CNT_W'(MAX_DIGITS)) begin
              store_we  = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        endcase
      end

      ST_K_MUL, ST_K_X10: begin
        alu_req.a = ALU_W'($signed(cand_r)) << 3;
        alu_req.b = ALU_W'($signed(cand_r)) << 1;
        cand_nxt  = alu_rsp.sum[HOST_W-1:0];
        state_nxt = (state_r == ST_K_MUL) ? ST_K_ADD : ST_RNG_MIN;
      end

      ST_K_ADD: begin
        alu_req.a = ALU_W'($signed(cand_r));
        alu_req.b = ALU_W'(store_r[idx_r]);
        cand_nxt  = alu_rsp.sum[HOST_W-1:0];
        idx_nxt   = idx_r + IDX_W'(1);
        if (!last_digit) begin
          state_nxt = ST_K_MUL;
        end else if (count_r < CNT_W'(3)) begin
          state_nxt = ST_K_X10;
        end else begin
          state_nxt = ST_RNG_MIN;
        end
      end

      ST_RNG_MIN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'($signed(cand_r));
        alu_req.b   = ALU_W'($signed(cfg.min_target));
        if (!alu_rsp.neg) begin
          state_nxt = ST_RNG_MAX;
        end else if (host_r) begin
          reply_nxt = REPLY_RANGE;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_K_FIN;
        end
      end

      ST_RNG_MAX: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'($signed(cfg.max_target));
        alu_req.b   = ALU_W'($signed(cand_r));
        if (!alu_rsp.neg) begin
          target_nxt = cand_r[TEMP_W-1:0];
        end
        if (!host_r) begin
          state_nxt = ST_K_FIN;
        end else if (alu_rsp.neg) begin
          reply_nxt = REPLY_RANGE;
          state_nxt = ST_DONE;
        end else begin
          pid_nxt   = 1'b1;
          reply_nxt = REPLY_ACCEPT;
          if (mode_r != MODE_RUN) begin
            mode_nxt = MODE_RUN;
            secs_nxt = '0;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_K_FIN: begin
        mode_nxt   = MODE_RUN;
        count_nxt  = '0;
        blank_nxt  = '0;
        best_nxt   = '0;
        nogain_nxt = '0;
        buzzer_nxt = 1'b0;
        pid_nxt    = 1'b1;
        secs_nxt   = '0;
        millis_nxt = '0;
        state_nxt  = ST_DONE;
      end

      ST_STOP: begin
        mode_nxt   = MODE_IDLE;
        stop_nxt   = 1'b1;
        secs_nxt   = '0;
        millis_nxt = '0;
        reply_nxt  = REPLY_ACCEPT;
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (cfg.load_default) begin
      target_nxt = cfg.default_target;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      target_r    <= DEFAULT_RST;
      count_r     <= '0;
      blank_r     <= '0;
      best_r      <= '0;
      nogain_r    <= '0;
      buzzer_r    <= 1'b0;
      millis_r    <= '0;
      secs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      target_r    <= target_nxt;
      count_r     <= count_nxt;
      blank_r     <= blank_nxt;
      best_r      <= best_nxt;
      nogain_r    <= nogain_nxt;
      buzzer_r    <= buzzer_nxt;
      millis_r    <= millis_nxt;
      secs_r      <= secs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r   <= meas_nxt;
    key_r    <= key_nxt;
    cand_r   <= cand_nxt;
    host_r   <= host_nxt;
    diff_r   <= diff_nxt;
    err_r    <= err_nxt;
    idx_r    <= idx_nxt;
    active_r <= active_nxt;
    pid_r    <= pid_nxt;
    stop_r   <= stop_nxt;
    reply_r  <= reply_nxt;
    if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= key_r;
    end
    if (out_load) begin
      out_mode_r   <= mode_r;
      out_buzzer_r <= buzzer_r;
      out_target_r <= target_r;
      out_secs_r   <= secs_r;
      out_active_r <= active_r;
      out_pid_r    <= pid_r;
      out_stop_r   <= stop_r;
      out_reply_r  <= reply_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.mode             = out_mode_r;
  assign out_ch.buzzer_on        = out_buzzer_r;
  assign out_ch.target_temp      = out_target_r;
  assign out_ch.run_seconds      = out_secs_r;
  assign out_ch.control_active   = out_active_r;
  assign out_ch.controller_reset = out_pid_r;
  assign out_ch.drive_stop       = out_stop_r;
  assign out_ch.host_reply       = out_reply_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after accepting a word");

  a_millis_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> millis_r < MS_PER_SEC)
    else $error("millisecond count not normalized between words");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised outside the done step");

endmodule

>>> tb/incubator_setpoint_and_alarm_supervisor_tb.sv
// Self-checking testbench for incubator_setpoint_and_alarm_supervisor: a directed table,
// then random ticks, keypad entries and host commands over several register settings.
// Depends on isas_pkg, the isas_in_if/isas_out_if channels and the RTL top level.
module incubator_setpoint_and_alarm_supervisor_tb import isas_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_SLOTS    = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 140;
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

  typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_MASK} stall_style_t;

  typedef struct packed {
    logic [1:0]               opcode;
    temp_t                    measured_temp;
    logic [3:0]               key_code;
    logic signed [HOST_W-1:0] host_target;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              buzzer_on;
    temp_t             target_temp;
    logic [SECS_W-1:0] run_seconds;
    logic              control_active;
    logic              controller_reset;
    logic              drive_stop;
    logic [1:0]        host_reply;
  } status_t;

  typedef struct {
    in_word_t w;
    bit       typed;
    status_t  want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  isas_in_if  in_ch ();
  isas_out_if out_ch ();

  incubator_setpoint_and_alarm_supervisor #(.MAX_DIGITS(DIGIT_SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register mirror
  logic [BAND_W-1:0]   band_cfg;
  temp_t               min_cfg;
  temp_t               max_cfg;
  temp_t               dflt_cfg;
  logic [CNT16_W-1:0]  startup_cfg;
  logic [CNT16_W-1:0]  stuck_cfg;
  logic [TICKMS_W-1:0] tickms_cfg;

  // supervisor state mirror
  logic [1:0]         m_mode;
  temp_t              m_target;
  logic [3:0]         m_digits [DIGIT_SLOTS];
  int                 m_count;
  logic [CNT16_W-1:0] m_blank;
  logic [BEST_W-1:0]  m_best;
  logic [CNT16_W-1:0] m_nogain;
  logic               m_buzzer;
  logic [MS_W-1:0]    m_millis;
  logic [SECS_W-1:0]  m_secs;

  status_t expected_status [$];
  int      mismatches;
  int      results_seen;
  int      stalled_cycles;
  int      burst_left;
  int      words_offered;
  int      far_offset;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit within_limits(input int v);
    return v >= int'(min_cfg) && v <= int'(max_cfg);
  endfunction

  function automatic void clear_alarm();
    m_blank = '0;
    m_best = '0;
    m_nogain = '0;
  endfunction

  function automatic status_t supervise_word(input in_word_t w);
    status_t s;
    int diff, err, raw, val, i;
    s = '0;
    case (w.opcode)
      OP_TICK: begin
        diff = int'(w.measured_temp) - int'(m_target);
        err = diff < 0 ? -diff : diff;
        if (m_mode != MODE_RUN && m_mode != MODE_ALARM) begin
          m_buzzer = 1'b0;
        end else if (m_blank < startup_cfg) begin
          m_blank++;
          m_buzzer = 1'b0;
        end else if (err <= int'(band_cfg)) begin
          m_nogain = '0;
          m_best = '0;
          if (m_mode == MODE_ALARM) m_mode = MODE_RUN;
          m_buzzer = 1'b0;
        end else begin
          if (m_best == 0 || err < int'(m_best)) begin
            m_best = err[BEST_W-1:0];
            m_nogain = '0;
          end else if (m_nogain != 16'hFFFF) begin
            m_nogain++;
          end
          if (m_nogain >= stuck_cfg) begin
            m_mode = MODE_ALARM;
            m_buzzer = 1'b1;
          end
        end
        if (m_mode == MODE_RUN || m_mode == MODE_ALARM) begin
          s.control_active = 1'b1;
          m_millis = m_millis + tickms_cfg;
          if (m_millis >= MS_PER_SEC) begin
            m_secs = m_secs + m_millis / MS_PER_SEC;
            m_millis = m_millis % MS_PER_SEC;
          end
        end
      end
      OP_KEY: begin
        if (w.key_code == KEY_STAR) begin
          if (m_mode == MODE_SET) begin
            if (m_count > 0) m_count--;
          end else begin
            m_mode = MODE_SET;
            m_count = 0;
            m_digits = '{default: '0};
          end
        end else if (w.key_code == KEY_HASH) begin
          if (m_mode == MODE_SET) begin
            if (m_count > 0) begin
              raw = 0;
              for (i = 0; i < m_count; i++) raw = raw * 10 + int'(m_digits[i]);
              val = (m_count >= 3) ? raw : raw * 10;
              if (within_limits(val)) m_target = temp_t'(val);
            end
            m_mode = MODE_RUN;
            m_count = 0;
            clear_alarm();
            m_buzzer = 1'b0;
            s.controller_reset = 1'b1;
            m_secs = '0;
            m_millis = '0;
          end else if (m_mode == MODE_RUN) begin
            m_mode = MODE_IDLE;
            s.drive_stop = 1'b1;
            m_secs = '0;
            m_millis = '0;
          end else begin
            m_mode = MODE_RUN;
            clear_alarm();
            m_buzzer = 1'b0;
            m_secs = '0;
            m_millis = '0;
          end
        end else if (m_mode == MODE_SET && w.key_code <= KEY_DIGIT_MAX &&
                     m_count < DIGIT_SLOTS) begin
          m_digits[m_count] = w.key_code;
          m_count++;
        end
      end
      OP_HOST_SET: begin
        if (within_limits(int'(w.host_target))) begin
          m_target = temp_t'(int'(w.host_target));
          s.controller_reset = 1'b1;
          if (m_mode != MODE_RUN) begin
            m_mode = MODE_RUN;
            m_secs = '0;
          end
          s.host_reply = REPLY_ACCEPT;
        end else begin
          s.host_reply = REPLY_RANGE;
        end
      end
      default: begin
        m_mode = MODE_IDLE;
        s.drive_stop = 1'b1;
        m_secs = '0;
        m_millis = '0;
        s.host_reply = REPLY_ACCEPT;
      end
    endcase
    s.mode = m_mode;
    s.buzzer_on = m_buzzer;
    s.target_temp = m_target;
    s.run_seconds = m_secs;
    return s;
  endfunction

  function automatic stim_row_t drow(input logic [1:0] op, input int temp, input int key,
                                     input int host);
    stim_row_t r;
    r.w.opcode = op;
    r.w.measured_temp = 12'(temp);
    r.w.key_code = 4'(key);
    r.w.host_target = 15'(host);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t trow(input logic [1:0] op, input int temp, input int key,
                                     input int host, input logic [1:0] mode, input int target,
                                     input bit pid, input bit stop, input logic [1:0] reply);
    stim_row_t r;
    r = drow(op, temp, key, host);
    r.typed = 1'b1;
    r.want.mode = mode;
    r.want.target_temp = 12'(target);
    r.want.controller_reset = pid;
    r.want.drive_stop = stop;
    r.want.host_reply = reply;
    return r;
  endfunction

  function automatic int any_temp();
    return int'($urandom_range(0, 1800)) - 550;
  endfunction

  function automatic int any_host();
    return int'($urandom_range(0, 19998)) - 9999;
  endfunction

  function automatic int far_pick();
    int mag;
    mag = int'(band_cfg) + 1 + int'($urandom_range(0, 150));
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // Mostly near the target or parked at a fixed offset so the stuck detector trips.
  function automatic int pick_temp();
    int t, r;
    r = $urandom_range(0, 9);
    if (r < 3)
      t = int'(m_target) + int'($urandom_range(0, 2 * int'(band_cfg))) - int'(band_cfg);
    else if (r < 8)
      t = int'(m_target) + far_offset;
    else
      t = any_temp();
    if (t < -550) t = -550;
    if (t > 1250) t = 1250;
    return t;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic offer_word(input stim_row_t r);
    status_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= r.w.opcode;
    in_ch.measured_temp <= r.w.measured_temp;
    in_ch.key_code      <= r.w.key_code;
    in_ch.host_target   <= r.w.host_target;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = supervise_word(r.w);
    expected_status.push_back(r.typed ? r.want : predicted);
    burst_left--;
    if (!(r.w.opcode == OP_KEY && r.w.key_code > KEY_HASH)) words_offered++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      CFG_IDX_BAND:    band_cfg = value[BAND_W-1:0];
      CFG_IDX_MIN:     min_cfg = value[TEMP_W-1:0];
      CFG_IDX_MAX:     max_cfg = value[TEMP_W-1:0];
      CFG_IDX_DEFAULT: begin
        dflt_cfg = value[TEMP_W-1:0];
        m_target = dflt_cfg;
      end
      CFG_IDX_STARTUP: startup_cfg = value[CNT16_W-1:0];
      CFG_IDX_STUCK:   stuck_cfg = value[CNT16_W-1:0];
      CFG_IDX_TICKMS:  tickms_cfg = value[TICKMS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input int band, input int lo, input int hi, input int dflt,
                               input int startup, input int stuck, input int tick);
    write_reg(CFG_IDX_BAND, band);
    write_reg(CFG_IDX_MIN, lo);
    write_reg(CFG_IDX_MAX, hi);
    write_reg(CFG_IDX_DEFAULT, dflt);
    write_reg(CFG_IDX_STARTUP, startup);
    write_reg(CFG_IDX_STUCK, stuck);
    write_reg(CFG_IDX_TICKMS, tick);
    far_offset = far_pick();
  endtask

  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.mode             = out_ch.mode;
      got.buzzer_on        = out_ch.buzzer_on;
      got.target_temp      = out_ch.target_temp;
      got.run_seconds      = out_ch.run_seconds;
      got.control_active   = out_ch.control_active;
      got.controller_reset = out_ch.controller_reset;
      got.drive_stop       = out_ch.drive_stop;
      got.host_reply       = out_ch.host_reply;
      results_seen++;
      if (expected_status.size() == 0) begin
        $display("%0t: result word with none expected, mode %0h target %0h", $time,
                 got.mode, got.target_temp);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
        check_field("target_temp", want.target_temp, got.target_temp);
        check_field("run_seconds", want.run_seconds, got.run_seconds);
        check_field("control_active", want.control_active, got.control_active);
        check_field("controller_reset", want.controller_reset, got.controller_reset);
        check_field("drive_stop", want.drive_stop, got.drive_stop);
        check_field("host_reply", want.host_reply, got.host_reply);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stalled_cycles <= 0;
    else if (in_ch.valid || expected_status.size() != 0)
      stalled_cycles <= stalled_cycles + 1;
  end

  initial begin
    wait (stalled_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // result side: randomly redrawn stall styles, one long hold-off
  initial begin
    stall_style_t style;
    int mask, cyc;
    bit held;
    style = READY_ALWAYS;
    mask = 1;
    cyc = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (cyc % 48 == 0) begin
        style = stall_style_t'($urandom_range(0, 3));
        mask = $urandom_range(1, 255);
      end
      case (style)
        READY_ALWAYS: out_ch.ready <= 1'b1;
        READY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        READY_MOSTLY: out_ch.ready <= ($urandom_range(0, 6) != 0);
        default:      out_ch.ready <= mask[cyc % 8];
      endcase
    end
  end

  initial begin
    stim_row_t directed [$];
    int digits [$];
    int phase, pick, n, k, v, lo, hi, base;

    mismatches = 0;
    results_seen = 0;
    stalled_cycles = 0;
    burst_left = 0;
    words_offered = 0;
    far_offset = 100;

    band_cfg    = BAND_RST;
    min_cfg     = MIN_RST;
    max_cfg     = MAX_RST;
    dflt_cfg    = DEFAULT_RST;
    startup_cfg = STARTUP_RST;
    stuck_cfg   = STUCK_RST;
    tickms_cfg  = TICKMS_RST;
    m_mode      = MODE_IDLE;
    m_target    = DEFAULT_RST;
    m_digits    = '{default: '0};
    m_count     = 0;
    clear_alarm();
    m_buzzer    = 1'b0;
    m_millis    = '0;
    m_secs      = '0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_TICK;
    in_ch.measured_temp <= '0;
    in_ch.key_code      <= '0;
    in_ch.host_target   <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: band 20, limits 200..600, target 370, long blanking
    directed.push_back(trow(OP_TICK, 250, 0, 0, MODE_IDLE, 370, 0, 0, REPLY_NONE));
    directed.push_back(trow(OP_HOST_STOP, 0, 0, 0, MODE_IDLE, 370, 0, 1, REPLY_ACCEPT));
    directed.push_back(trow(OP_HOST_SET, 0, 0, 9999, MODE_IDLE, 370, 0, 0, REPLY_RANGE));
    directed.push_back(trow(OP_HOST_SET, 0, 0, -9999, MODE_IDLE, 370, 0, 0, REPLY_RANGE));
    directed.push_back(trow(OP_HOST_SET, 0, 0, 600, MODE_RUN, 600, 1, 0, REPLY_ACCEPT));
    directed.push_back(trow(OP_HOST_SET, 0, 0, 200, MODE_RUN, 200, 1, 0, REPLY_ACCEPT));
    directed.push_back(drow(OP_TICK, -550, 0, 0));
    directed.push_back(drow(OP_TICK, 1250, 0, 0));
    directed.push_back(drow(OP_KEY, 0, 15, 0));
    directed.push_back(drow(OP_KEY, 0, 5, 0));
    directed.push_back(trow(OP_KEY, 0, KEY_HASH, 0, MODE_IDLE, 200, 0, 1, REPLY_NONE));
    directed.push_back(trow(OP_KEY, 0, KEY_STAR, 0, MODE_SET, 200, 0, 0, REPLY_NONE));
    directed.push_back(drow(OP_KEY, 0, KEY_STAR, 0));
    directed.push_back(trow(OP_KEY, 0, KEY_HASH, 0, MODE_RUN, 200, 1, 0, REPLY_NONE));
    directed.push_back(drow(OP_KEY, 0, KEY_STAR, 0));
    directed.push_back(drow(OP_KEY, 0, 4, 0));
    directed.push_back(drow(OP_KEY, 0, 5, 0));
    directed.push_back(drow(OP_KEY, 0, KEY_HASH, 0));
    directed.push_back(drow(OP_KEY, 0, KEY_STAR, 0));
    directed.push_back(drow(OP_KEY, 0, 3, 0));
    directed.push_back(drow(OP_KEY, 0, 7, 0));
    directed.push_back(drow(OP_KEY, 0, 2, 0));
    directed.push_back(drow(OP_KEY, 0, 9, 0));
    directed.push_back(drow(OP_KEY, 0, 9, 0));
    directed.push_back(drow(OP_KEY, 0, KEY_STAR, 0));
    directed.push_back(drow(OP_KEY, 0, KEY_HASH, 0));
    foreach (directed[i]) offer_word(directed[i]);

    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          load_settings(20, 200, 600, 370, 0, 3, 200);
          write_reg(CFG_IDX_SPARE, 32'h0000_05A5);
        end
        1: load_settings(1, -550, 1250, -550, 2, 1, 1000);
        2: load_settings(500, 300, 300, 1250, 5, 0, 0);
        3: load_settings(10, 600, 200, 0, 65535, 65535, 1);
        default: begin
          lo = int'($urandom_range(0, 1150)) - 550;
          hi = lo + int'($urandom_range(0, 600));
          if (hi > 1250) hi = 1250;
          load_settings($urandom_range(1, 80), lo, hi, lo + int'($urandom_range(0, hi - lo)),
                        $urandom_range(0, 12), $urandom_range(1, 10),
                        $urandom_range(1, 1000));
        end
      endcase

      base = words_offered;
      while (words_offered - base < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        lo = int'(min_cfg);
        hi = int'(max_cfg);
        if (pick < 55) begin
          if ($urandom_range(0, 29) == 0) far_offset = far_pick();
          offer_word(drow(OP_TICK, pick_temp(), $urandom_range(0, 15), any_host()));
        end else if (pick < 75) begin
          digits.delete();
          v = (lo > 100) ? lo : 100;
          if ($urandom_range(0, 1) && v <= hi) begin
            v = v + int'($urandom_range(0, hi - v));
            if (v % 10 == 0 && v < 1000 && $urandom_range(0, 1)) v = v / 10;
            while (v > 0) begin
              digits.push_front(v % 10);
              v = v / 10;
            end
          end else begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) digits.push_back($urandom_range(0, 9));
          end
          offer_word(drow(OP_KEY, any_temp(), KEY_STAR, any_host()));
          foreach (digits[i]) begin
            offer_word(drow(OP_KEY, any_temp(), digits[i], any_host()));
            if ($urandom_range(0, 11) == 0)
              offer_word(drow(OP_KEY, any_temp(), KEY_STAR, any_host()));
          end
          if ($urandom_range(0, 7) != 0)
            offer_word(drow(OP_KEY, any_temp(), KEY_HASH, any_host()));
        end else if (pick < 82) begin
          offer_word(drow(OP_KEY, any_temp(), KEY_HASH, any_host()));
        end else if (pick < 87) begin
          offer_word(drow(OP_KEY, any_temp(), $urandom_range(0, 15), any_host()));
        end else if (pick < 96) begin
          if (lo <= hi && $urandom_range(0, 9) < 7)
            v = lo + int'($urandom_range(0, hi - lo));
          else
            v = any_host();
          offer_word(drow(OP_HOST_SET, any_temp(), $urandom_range(0, 15), v));
        end else begin
          offer_word(drow(OP_HOST_STOP, any_temp(), $urandom_range(0, 15), any_host()));
        end
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/isas_pkg.sv
hw/rtl/isas_if.sv
hw/rtl/isas_alu.sv
hw/rtl/isas_cfg.sv
hw/rtl/incubator_setpoint_and_alarm_supervisor.sv
tb/incubator_setpoint_and_alarm_supervisor_tb.sv
